// ----- hw/rtl/sbrd_pkg.sv -----
// Shared types, widths and constants of the sampled barcode run decoder.
`timescale 1ns / 1ps

package sbrd_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int CODE_W          = 32;
    localparam int SHIFT_W         = $clog2(CODE_W);
    localparam int BIT_SAMPLES_W   = 10;
    localparam int BIT_TOL_W       = 10;
    localparam int CODE_LEN_W      = 6;
    localparam int THRESHOLD_W     = 16;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 16;

    localparam int MAX_FRAME_SAMPLES = 65536;
    localparam int QUOT_W          = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int ADV_W           = $clog2(MAX_FRAME_SAMPLES + 2);
    localparam int BITS_SAT        = 127;
    localparam int BITS_W          = $clog2(BITS_SAT + 1);
    localparam int SUM_W           = ADV_W + 1;

    localparam int LEAD_SKIP       = 10;
    localparam int LEAD_W          = $clog2(LEAD_SKIP + 1);

    // Division of the tolerance by three as a multiply by a scaled reciprocal.
    localparam int TOL_DIV3_MUL    = 683;
    localparam int TOL_DIV3_SHIFT  = 11;
    localparam int TOL_PROD_W      = 20;
    localparam int TOL_THIRD_W     = TOL_PROD_W - TOL_DIV3_SHIFT;
    localparam int START_W         =
        $clog2((1 << BIT_SAMPLES_W) + (1 << BIT_TOL_W) / 3 + 2);

    localparam logic [BIT_SAMPLES_W-1:0] RST_BIT_SAMPLES   = 10'd20;
    localparam logic [BIT_TOL_W-1:0]     RST_BIT_TOLERANCE = 10'd12;
    localparam logic [CODE_LEN_W-1:0]    RST_CODE_LENGTH   = 6'd18;
    localparam logic [THRESHOLD_W-1:0]   RST_THRESHOLD     = 16'd60000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BIT_SAMPLES      = 4'd0,
        CFG_BIT_TOLERANCE    = 4'd1,
        CFG_CODE_LENGTH      = 4'd2,
        CFG_BRIGHT_THRESHOLD = 4'd3
    } cfg_index_t;

    typedef struct packed {
        logic [THRESHOLD_W-1:0]   bright_threshold;
        logic [CODE_LEN_W-1:0]    code_length;
        logic [BIT_TOL_W-1:0]     bit_tolerance;
        logic [BIT_SAMPLES_W-1:0] bit_samples;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0]     code;
        logic [BITS_W-1:0]     bits;
        logic [CODE_LEN_W-1:0] target;
    } snap_t;

endpackage

// ----- hw/rtl/sbrd_cfg_regs.sv -----
// Configuration register file of the sampled barcode run decoder.
`timescale 1ns / 1ps

module sbrd_cfg_regs import sbrd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_samples      <= RST_BIT_SAMPLES;
            cfg_reg.bit_tolerance    <= RST_BIT_TOLERANCE;
            cfg_reg.code_length      <= RST_CODE_LENGTH;
            cfg_reg.bright_threshold <= RST_THRESHOLD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_BIT_SAMPLES: begin
                    cfg_reg.bit_samples <= cfg_data[BIT_SAMPLES_W-1:0];
                end
                CFG_BIT_TOLERANCE: begin
                    cfg_reg.bit_tolerance <= cfg_data[BIT_TOL_W-1:0];
                end
                CFG_CODE_LENGTH: begin
                    cfg_reg.code_length <= cfg_data[CODE_LEN_W-1:0];
                end
                CFG_BRIGHT_THRESHOLD: begin
                    cfg_reg.bright_threshold <= cfg_data[THRESHOLD_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/sbrd_run_tracker.sv -----
// Input register and per-sample run measurement and bit accumulation.
`timescale 1ns / 1ps

module sbrd_run_tracker import sbrd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic                s_last,
    input  cfg_t                cfg,
    output logic                snap_valid,
    input  logic                snap_ready,
    output snap_t               snap
);

    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_SEEK   = 4'b0010,
        PH_START  = 4'b0100,
        PH_DECODE = 4'b1000
    } phase_t;

    localparam logic [CODE_W-1:0] ALL_ONES = '1;

    logic                     in_valid_reg;
    logic [SAMPLE_W-1:0]      in_sample_reg;
    logic                     in_last_reg;
    phase_t                   phase_reg, phase_next;
    logic [LEAD_W-1:0]        lead_reg, lead_next;
    logic [START_W-1:0]       start_cnt_reg, start_cnt_next;
    logic                     in_bright_reg, in_bright_next;
    logic [QUOT_W-1:0]        quot_reg, quot_next;
    logic [BIT_SAMPLES_W-1:0] rem_reg, rem_next;
    logic [BITS_W-1:0]        bits_reg, bits_next;
    logic [CODE_W-1:0]        code_reg, code_next;
    logic                     snap_valid_reg;
    snap_t                    snap_reg;

    logic                     in_advance;
    logic                     bright;
    logic [BIT_SAMPLES_W-1:0] eff_bits;
    logic [CODE_LEN_W-1:0]    target;
    logic [BITS_W-1:0]        target_ext;
    logic [TOL_PROD_W-1:0]    tol_prod;
    logic [TOL_THIRD_W-1:0]   tol_third;
    logic [START_W-1:0]       start_limit;
    logic                     decode_en;
    logic                     ib_cur;
    logic                     change;
    logic [ADV_W-1:0]         adv;
    logic [CODE_W-1:0]        code_closed;
    logic [SUM_W-1:0]         bits_sum;
    logic [BITS_W-1:0]        bits_closed;
    logic [CODE_W-1:0]        code_c;
    logic [BITS_W-1:0]        bits_c;
    logic                     ib_c;
    logic [QUOT_W-1:0]        quot_c;
    logic [BIT_SAMPLES_W-1:0] rem_c;
    logic [BIT_SAMPLES_W:0]   rem_inc;
    logic                     count_en;

    // A last beat waits only when the snapshot slot is still occupied.
    assign in_advance = in_valid_reg && (!in_last_reg || !snap_valid_reg || snap_ready);
    assign s_tready   = !in_valid_reg || in_advance;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    always_comb begin
        bright      = in_sample_reg > cfg.bright_threshold;
        eff_bits    = (cfg.bit_samples == '0) ? BIT_SAMPLES_W'(1) : cfg.bit_samples;
        target      = (cfg.code_length == '0) ? '0 : cfg.code_length - CODE_LEN_W'(1);
        target_ext  = BITS_W'(target);
        tol_prod    = TOL_PROD_W'(cfg.bit_tolerance) * TOL_PROD_W'(TOL_DIV3_MUL);
        tol_third   = tol_prod[TOL_PROD_W-1:TOL_DIV3_SHIFT];
        start_limit = START_W'(eff_bits) + START_W'(tol_third);

        phase_next     = phase_reg;
        lead_next      = lead_reg;
        start_cnt_next = start_cnt_reg;
        ib_cur         = in_bright_reg;
        decode_en      = 1'b0;

        case (phase_reg)
            PH_LEAD: begin
                lead_next = lead_reg + LEAD_W'(1);
                if (lead_next >= LEAD_W'(LEAD_SKIP)) begin
                    phase_next = PH_SEEK;
                end
            end
            PH_SEEK, PH_START: begin
                if (phase_reg == PH_START || !bright) begin
                    phase_next = PH_START;
                    if (bright) begin
                        ib_cur     = 1'b1;
                        phase_next = PH_DECODE;
                        decode_en  = 1'b1;
                    end else begin
                        start_cnt_next = start_cnt_reg + START_W'(1);
                        if (start_cnt_next > start_limit) begin
                            ib_cur     = 1'b0;
                            phase_next = PH_DECODE;
                            decode_en  = 1'b1;
                        end
                    end
                end
            end
            PH_DECODE: begin
                decode_en = 1'b1;
            end
            default: begin
                phase_next = PH_LEAD;
            end
        endcase

        // Closing the current run turns it into whole bits plus a rounded partial bit.
        change = bright != ib_cur;
        adv    = ADV_W'(quot_reg) + ADV_W'(rem_reg > cfg.bit_tolerance);
        if (adv > ADV_W'(CODE_W - 1)) begin
            code_closed = ib_cur ? '0 : ALL_ONES;
        end else begin
            code_closed = (code_reg << adv[SHIFT_W-1:0])
                        | (ib_cur ? '0 : ~(ALL_ONES << adv[SHIFT_W-1:0]));
        end
        bits_sum    = SUM_W'(bits_reg) + SUM_W'(adv);
        bits_closed = (bits_sum > SUM_W'(BITS_SAT)) ? BITS_W'(BITS_SAT)
                                                    : bits_sum[BITS_W-1:0];

        if (change) begin
            code_c = code_closed;
            bits_c = bits_closed;
            ib_c   = !ib_cur;
            quot_c = '0;
            rem_c  = '0;
        end else begin
            code_c = code_reg;
            bits_c = bits_reg;
            ib_c   = ib_cur;
            quot_c = quot_reg;
            rem_c  = rem_reg;
        end

        count_en = !(change && (bits_closed >= target_ext));
        rem_inc  = (BIT_SAMPLES_W + 1)'(rem_c) + (BIT_SAMPLES_W + 1)'(1);

        code_next      = code_reg;
        bits_next      = bits_reg;
        in_bright_next = ib_cur;
        quot_next      = quot_reg;
        rem_next       = rem_reg;

        if (decode_en && (bits_reg < target_ext)) begin
            code_next      = code_c;
            bits_next      = bits_c;
            in_bright_next = ib_c;
            quot_next      = quot_c;
            rem_next       = rem_c;
            if (count_en) begin
                if (rem_inc >= (BIT_SAMPLES_W + 1)'(eff_bits)) begin
                    rem_next  = '0;
                    quot_next = (quot_c < QUOT_W'(MAX_FRAME_SAMPLES))
                              ? quot_c + QUOT_W'(1) : quot_c;
                end else begin
                    rem_next = rem_inc[BIT_SAMPLES_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_sample;
            in_last_reg   <= s_last;
        end
        if (in_advance && in_last_reg) begin
            snap_reg.code   <= code_next;
            snap_reg.bits   <= bits_next;
            snap_reg.target <= target;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            phase_reg      <= PH_LEAD;
            lead_reg       <= '0;
            start_cnt_reg  <= '0;
            in_bright_reg  <= 1'b0;
            quot_reg       <= '0;
            rem_reg        <= '0;
            bits_reg       <= '0;
            code_reg       <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (in_advance && in_last_reg) begin
                snap_valid_reg <= 1'b1;
            end else if (snap_ready) begin
                snap_valid_reg <= 1'b0;
            end
            if (in_advance) begin
                if (in_last_reg) begin
                    phase_reg     <= PH_LEAD;
                    lead_reg      <= '0;
                    start_cnt_reg <= '0;
                    in_bright_reg <= 1'b0;
                    quot_reg      <= '0;
                    rem_reg       <= '0;
                    bits_reg      <= '0;
                    code_reg      <= '0;
                end else begin
                    phase_reg     <= phase_next;
                    lead_reg      <= lead_next;
                    start_cnt_reg <= start_cnt_next;
                    in_bright_reg <= in_bright_next;
                    quot_reg      <= quot_next;
                    rem_reg       <= rem_next;
                    bits_reg      <= bits_next;
                    code_reg      <= code_next;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/sbrd_aligner.sv -----
// Trims or extends the finished code and aligns it to whole bytes in the output register.
`timescale 1ns / 1ps

module sbrd_aligner import sbrd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              snap_valid,
    output logic              snap_ready,
    input  snap_t             snap,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CODE_W-1:0] m_tdata
);

    logic              m_tvalid_reg;
    logic [CODE_W-1:0] m_tdata_reg;
    logic [BITS_W-1:0] target_ext;
    logic [BITS_W-1:0] shift_amt;
    logic [CODE_W-1:0] fitted;
    logic [2:0]        pad;
    logic [CODE_W-1:0] aligned;

    assign snap_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    always_comb begin
        target_ext = BITS_W'(snap.target);
        if (snap.bits > target_ext) begin
            shift_amt = snap.bits - target_ext;
            fitted    = (shift_amt > BITS_W'(CODE_W - 1)) ? '0
                                                          : snap.code >> shift_amt[SHIFT_W-1:0];
        end else begin
            shift_amt = target_ext - snap.bits;
            fitted    = (shift_amt > BITS_W'(CODE_W - 1)) ? '0
                                                          : snap.code << shift_amt[SHIFT_W-1:0];
        end
        // Padding up to the next byte boundary.
        pad     = 3'(4'd8 - {1'b0, snap.target[2:0]});
        aligned = fitted << pad;
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            m_tdata_reg <= aligned;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (snap_ready) begin
            m_tvalid_reg <= snap_valid;
        end
    end

endmodule

// ----- hw/rtl/sampled_barcode_run_decoder.sv -----
// Top level of the sampled barcode run decoder.
//
// Light samples of one scan enter on the s_ channel, one beat per sample, with
// s_tlast on the final sample of the frame. The first ten samples are skipped,
// the leading dark run is measured, and each later run is turned into bits of
// the barcode. One beat leaves on the m_ channel for each frame, carrying the
// decoded code left aligned to whole bytes.
// The cfg_ channel writes the four settings by index; it is always ready and a
// write is meant to happen while no frame is in flight.
// A last beat accepted on the s_ channel passes through the input register and
// the snapshot register before its result is presented on m_tvalid.
// Throughput: one sample per cycle while no last beat waits; the run update
// between the input register and the run state registers is combinational.
// When the receiver stalls, samples that do not end a frame keep flowing; a
// last beat waits in the input register once both the snapshot and the output
// registers are full, and s_tready falls until m_tready returns.
// A synchronous reset on aresetn restores the default settings and empties all
// registers, so the next beat starts a new frame.
`timescale 1ns / 1ps

module sampled_barcode_run_decoder import sbrd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_W-1:0]    s_tdata,    // [15:0] sample
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [CODE_W-1:0]      m_tdata,    // [31:0] barcode_value
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg;
    logic  snap_valid;
    logic  snap_ready;
    snap_t snap;

    sbrd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sbrd_run_tracker u_run_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_sample   (s_tdata),
        .s_last     (s_tlast),
        .cfg        (cfg),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    sbrd_aligner u_aligner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ----- hw/rtl/sbrd_checker.sv -----
// Port-level assertions for the sampled barcode run decoder and their binding.
`timescale 1ns / 1ps

module sbrd_checker import sbrd_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [CODE_W-1:0] m_tdata
);

    // Reset empties the output register.
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set in the cycle after reset");

    // Reset leaves the input side free to take a beat.
    a_reset_frees_input: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("s_tready low in the cycle after reset");

    // The input side only stalls when a result is held by the receiver.
    a_stall_needs_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // A result beat that is not taken stays on the bus unchanged.
    a_output_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind sampled_barcode_run_decoder sbrd_checker u_sbrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sampled_barcode_run_decoder_checker.sv -----
// Checker that predicts and compares the decoded barcode of every frame.
`timescale 1ns / 1ps

module sampled_barcode_run_decoder_checker import sbrd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [SAMPLE_W-1:0]    s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [CODE_W-1:0]      m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   end_of_run,
    output int unsigned            pending,
    output int unsigned            errors,
    output int unsigned            samples_seen,
    output int unsigned            results_seen
);

    typedef enum logic [1:0] {
        SKIP_LEAD,
        SEEK_DARK,
        MEASURE_START,
        DECODE_RUNS
    } scan_phase_e;

    logic [BIT_SAMPLES_W-1:0] cfg_width;
    logic [BIT_TOL_W-1:0]     cfg_tol;
    logic [CODE_LEN_W-1:0]    cfg_len;
    logic [THRESHOLD_W-1:0]   cfg_thr;

    scan_phase_e              scan_phase;
    int unsigned              lead_cnt;
    int unsigned              start_cnt;
    int unsigned              run_quot;
    int unsigned              run_rem;
    int unsigned              bits_cnt;
    bit                       in_bright;
    logic [CODE_W-1:0]        code_reg;

    logic [CODE_W-1:0]        expected_codes [$];
    bit                       flushed;

    function automatic int unsigned bit_width();
        return (cfg_width == 0) ? 1 : cfg_width;
    endfunction

    function automatic int unsigned code_bits();
        return (cfg_len == 0) ? 0 : cfg_len - 1;
    endfunction

    function automatic logic [CODE_W-1:0] shift_up(logic [CODE_W-1:0] v, int unsigned n);
        return (n >= CODE_W) ? '0 : v << n;
    endfunction

    function automatic logic [CODE_W-1:0] shift_down(logic [CODE_W-1:0] v, int unsigned n);
        return (n >= CODE_W) ? '0 : v >> n;
    endfunction

    function automatic void clear_frame();
        scan_phase = SKIP_LEAD;
        lead_cnt   = 0;
        start_cnt  = 0;
        run_quot   = 0;
        run_rem    = 0;
        bits_cnt   = 0;
        in_bright  = 1'b0;
        code_reg   = '0;
    endfunction

    // A finished run turns into whole bit widths, plus one when the remainder
    // is above the tolerance; dark runs give ones and bright runs zeros.
    function automatic void close_run();
        int unsigned adv;
        adv = run_quot + ((run_rem > cfg_tol) ? 1 : 0);
        if (adv >= CODE_W)
            code_reg = in_bright ? '0 : '1;
        else
            code_reg = (code_reg << adv) | (in_bright ? '0 : ((32'd1 << adv) - 32'd1));
        bits_cnt = bits_cnt + adv;
        if (bits_cnt > BITS_SAT)
            bits_cnt = BITS_SAT;
        in_bright = !in_bright;
        run_quot  = 0;
        run_rem   = 0;
    endfunction

    function automatic void decode_one(bit bright);
        if (bits_cnt >= code_bits())
            return;
        if (bright != in_bright) begin
            close_run();
            if (bits_cnt >= code_bits())
                return;
        end
        run_rem++;
        if (run_rem >= bit_width()) begin
            run_rem = 0;
            if (run_quot < MAX_FRAME_SAMPLES)
                run_quot++;
        end
    endfunction

    function automatic void predict_beat(logic [SAMPLE_W-1:0] smp, logic lst);
        bit                bright;
        int unsigned       tgt;
        int unsigned       pad;
        logic [CODE_W-1:0] v;
        bright = smp > cfg_thr;
        if (scan_phase == SKIP_LEAD) begin
            lead_cnt++;
            if (lead_cnt >= LEAD_SKIP)
                scan_phase = SEEK_DARK;
        end else begin
            if (scan_phase == SEEK_DARK && !bright)
                scan_phase = MEASURE_START;
            if (scan_phase == MEASURE_START) begin
                if (bright) begin
                    in_bright  = 1'b1;
                    scan_phase = DECODE_RUNS;
                end else begin
                    start_cnt++;
                    if (start_cnt > bit_width() + cfg_tol / 3) begin
                        in_bright  = 1'b0;
                        scan_phase = DECODE_RUNS;
                    end
                end
                if (scan_phase == DECODE_RUNS)
                    decode_one(bright);
            end else if (scan_phase == DECODE_RUNS) begin
                decode_one(bright);
            end
        end
        if (lst) begin
            tgt = code_bits();
            v   = code_reg;
            if (bits_cnt > tgt)
                v = shift_down(v, bits_cnt - tgt);
            else if (bits_cnt < tgt)
                v = shift_up(v, tgt - bits_cnt);
            pad = ((tgt + 7) / 8) * 8 - tgt;
            expected_codes.push_back(shift_up(v, pad));
            clear_frame();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] checker: %s", $time, what);
        errors++;
    endtask

    always @(posedge aclk) begin : watch
        logic [CODE_W-1:0] want;
        if (!aresetn) begin
            cfg_width = RST_BIT_SAMPLES;
            cfg_tol   = RST_BIT_TOLERANCE;
            cfg_len   = RST_CODE_LENGTH;
            cfg_thr   = RST_THRESHOLD;
            clear_frame();
            expected_codes.delete();
            flushed = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("result beat 0x%08h with no frame waiting",
                                              m_tdata));
                end else begin
                    want = expected_codes.pop_front();
                    results_seen++;
                    if (m_tdata !== want)
                        report_mismatch($sformatf("frame %0d: barcode 0x%08h, expected 0x%08h",
                                                  results_seen, m_tdata, want));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BIT_SAMPLES:      cfg_width = cfg_data[BIT_SAMPLES_W-1:0];
                    CFG_BIT_TOLERANCE:    cfg_tol   = cfg_data[BIT_TOL_W-1:0];
                    CFG_CODE_LENGTH:      cfg_len   = cfg_data[CODE_LEN_W-1:0];
                    CFG_BRIGHT_THRESHOLD: cfg_thr   = cfg_data[THRESHOLD_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                samples_seen++;
                predict_beat(s_tdata, s_tlast);
            end
            if (end_of_run && !flushed) begin
                flushed = 1'b1;
                if (expected_codes.size() != 0)
                    report_mismatch($sformatf("%0d decoded frames never came out",
                                              expected_codes.size()));
            end
        end
        pending = expected_codes.size();
    end

endmodule

// ----- tb/sampled_barcode_run_decoder_test.sv -----
// Testbench top: clock, reset, stimulus and verdict for the barcode run decoder.
`timescale 1ns / 1ps

module sampled_barcode_run_decoder_test;
    import sbrd_pkg::*;

    localparam int unsigned RANDOM_SAMPLES = 550;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned STALL_LIMIT    = 20000;
    localparam int unsigned SAT_RUN        = 140;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [CODE_W-1:0]      m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   end_of_run;

    int unsigned            pending;
    int unsigned            errors;
    int unsigned            samples_seen;
    int unsigned            results_seen;

    int unsigned            cur_width = 20;
    int unsigned            cur_tol   = 12;
    int unsigned            cur_thr   = 60000;
    int unsigned            tx_gap_pct;
    int unsigned            rx_stall_pct;
    int unsigned            settings_used;
    int unsigned            live_samples;
    int unsigned            quiet_cycles;
    bit                     hold_req;
    logic [SAMPLE_W-1:0]    frame_q [$];

    sampled_barcode_run_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sampled_barcode_run_decoder_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .end_of_run   (end_of_run),
        .pending      (pending),
        .errors       (errors),
        .samples_seen (samples_seen),
        .results_seen (results_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles.", STALL_LIMIT);
            $display("** sampled_barcode_run_decoder: FAILED **");
            $finish;
        end
    end

    // The receiver stalls at random, and on request holds off for a long
    // stretch so that the decoder fills up and pushes back on its input.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    task automatic set_idling(input int unsigned mode);
        case (mode % 4)
            0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_gap_pct = 58; rx_stall_pct = 0;  end
            2: begin tx_gap_pct = 0;  rx_stall_pct = 58; end
            default: begin tx_gap_pct = 29; rx_stall_pct = 29; end
        endcase
    endtask

    task automatic send_smp(input logic [SAMPLE_W-1:0] smp, input logic lst);
        while (tx_gap_pct != 0 && $urandom_range(99, 0) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Settings change only between frames, once every decoded frame is back.
    task automatic program_regs(input int unsigned width, input int unsigned tol,
                                input int unsigned len, input int unsigned thr);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        put_reg(CFG_BIT_SAMPLES,      {6'($urandom), 10'(width)});
        put_reg(CFG_BIT_TOLERANCE,    {6'($urandom), 10'(tol)});
        put_reg(CFG_CODE_LENGTH,      {10'($urandom), 6'(len)});
        put_reg(CFG_BRIGHT_THRESHOLD, 16'(thr));
        cfg_valid <= 1'b0;
        cur_width = width % 1024;
        cur_tol   = tol % 1024;
        cur_thr   = thr % 65536;
        settings_used++;
    endtask

    function automatic logic [SAMPLE_W-1:0] light(bit bright);
        if (bright && cur_thr != 65535)
            return 16'($urandom_range(65535, cur_thr + 1));
        return 16'($urandom_range(cur_thr, 0));
    endfunction

    task automatic push_run(input bit bright, input int unsigned n);
        repeat (n) frame_q.push_back(light(bright));
    endtask

    // A plausible scan: skipped lead-in, a little bright margin, the start
    // run, then alternating runs shorter than three bit widths.
    task automatic build_barcode(input int unsigned max_runs);
        int unsigned w;
        int unsigned lim;
        int unsigned len;
        bit          colour;
        frame_q.delete();
        repeat (LEAD_SKIP) frame_q.push_back(16'($urandom));
        push_run(1'b1, $urandom_range(3, 0));
        w   = (cur_width == 0) ? 1 : cur_width;
        lim = w + cur_tol / 3;
        if ($urandom_range(2, 0) == 0)
            push_run(1'b0, lim + 1 + $urandom_range(w, 0));
        else
            push_run(1'b0, $urandom_range(lim, 1));
        colour = 1'b1;
        repeat ($urandom_range(max_runs, 1)) begin
            len = $urandom_range(2, 0) * w + $urandom_range(w - 1, 0);
            push_run(colour, (len == 0) ? 1 : len);
            colour = !colour;
        end
        frame_q.push_back(light($urandom_range(1, 0)));
    endtask

    task automatic build_noise(input int unsigned max_len);
        frame_q.delete();
        repeat ($urandom_range(max_len, 1)) frame_q.push_back(16'($urandom));
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) begin
            send_smp(frame_q[i], i == frame_q.size() - 1);
            if (i >= LEAD_SKIP)
                live_samples++;
        end
    endtask

    task automatic run_barcodes(input int unsigned count, input int unsigned max_runs);
        repeat (count) begin
            build_barcode(max_runs);
            send_frame();
        end
    endtask

    initial begin : stimulus
        int unsigned mode;
        int unsigned pick;
        int unsigned w;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_BIT_SAMPLES;
        cfg_data   = '0;
        end_of_run = 1'b0;
        hold_req   = 1'b0;
        set_idling(0);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default settings: frames that end before decoding starts, then a
        // full scan.
        frame_q = '{16'hFFFF};
        send_frame();
        frame_q.delete();
        repeat (5) begin
            frame_q.push_back(16'h0000);
            frame_q.push_back(16'hFFFF);
        end
        frame_q.push_back(16'hFFFF);
        frame_q.push_back(16'hFFFF);
        send_frame();
        frame_q.push_back(16'h0000);
        send_frame();
        run_barcodes(1, 12);

        // Extreme settings.
        program_regs(1, 0, 32, 32768);
        set_idling(1);
        run_barcodes(4, 10);
        program_regs(0, 1023, 2, 0);
        set_idling(2);
        run_barcodes(3, 10);
        program_regs(2, 1, 0, 65535);
        set_idling(3);
        run_barcodes(2, 10);
        program_regs(3, 2, 1, 40000);
        set_idling(0);
        run_barcodes(2, 10);
        program_regs(4, 3, 63, 20000);
        run_barcodes(3, 12);
        program_regs(1023, 0, 4, 30000);
        build_noise(40);
        send_frame();

        // One dark run long enough to saturate the bit count.
        program_regs(1, 0, 32, 60000);
        build_noise(1);
        frame_q.delete();
        repeat (LEAD_SKIP) frame_q.push_back(16'($urandom));
        push_run(1'b1, 1);
        push_run(1'b0, SAT_RUN);
        push_run(1'b1, 1);
        push_run(1'b0, 1);
        send_frame();

        // Receiver holds off while short frames keep coming.
        program_regs(2, 1, 9, 30000);
        hold_req = 1'b1;
        repeat (12) begin
            build_noise(4);
            send_frame();
        end

        mode = 0;
        live_samples = 0;
        while (live_samples < RANDOM_SAMPLES) begin
            w = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(5, 1);
            pick = $urandom_range(9, 0);
            program_regs(w, $urandom_range(2 * w + 2, 0),
                         (pick == 0) ? 63 : (pick == 1) ? $urandom_range(1, 0)
                                                        : $urandom_range(33, 2),
                         (pick == 2) ? 0 : (pick == 3) ? 65535
                                                       : $urandom_range(62000, 2000));
            set_idling(mode);
            mode++;
            repeat (6) begin
                pick = $urandom_range(9, 0);
                if (pick < 9)
                    build_barcode(10);
                else
                    build_noise(30);
                if (pick == 7 || pick == 8)
                    while (frame_q.size() > $urandom_range(frame_q.size(), 1))
                        void'(frame_q.pop_back());
                send_frame();
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        end_of_run <= 1'b1;
        @(negedge aclk);
        @(negedge aclk);
        $display("Run covered %0d samples and %0d decoded frames under %0d register settings,",
                 samples_seen, results_seen, settings_used + 1);
        $display("with sender gaps, receiver stalls and one long receiver hold-off.");
        if (errors == 0)
            $display("** sampled_barcode_run_decoder: PASSED **");
        else
            $display("** sampled_barcode_run_decoder: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sbrd_pkg.sv
hw/rtl/sbrd_cfg_regs.sv
hw/rtl/sbrd_run_tracker.sv
hw/rtl/sbrd_aligner.sv
hw/rtl/sampled_barcode_run_decoder.sv
hw/rtl/sbrd_checker.sv
tb/sampled_barcode_run_decoder_checker.sv
tb/sampled_barcode_run_decoder_test.sv
